@@ rtl/lsb_stego_extractor_top_assert.svh @@
// Assertion macros for the LSB steganography extractor checker.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef LSB_STEGO_EXTRACTOR_TOP_ASSERT_SVH
`define LSB_STEGO_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define LSE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lse check failed");

// Next-cycle implication, sampled on the rising clock edge
`define LSE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lse check failed");

`endif

@@ rtl/lse_pkg.sv @@
// Shared types and constants for the LSB steganography extractor.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package lse_pkg;

  // Parse phases, one-hot
  typedef enum logic [6:0] {
    PH_HEADER   = 7'b0000001,
    PH_MAGIC    = 7'b0000010,
    PH_EXT_LEN  = 7'b0000100,
    PH_EXT_CHR  = 7'b0001000,
    PH_DAT_LEN  = 7'b0010000,
    PH_DAT_BYTE = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_EXT_LEN  = 3'd0;
  localparam logic [2:0] KIND_EXT_CHR  = 3'd1;
  localparam logic [2:0] KIND_DAT_LEN  = 3'd2;
  localparam logic [2:0] KIND_DAT_BYTE = 3'd3;
  localparam logic [2:0] KIND_MISMATCH = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_HEADER_BYTES   = 2'd0;
  localparam logic [1:0] REG_EXPECTED_MAGIC = 2'd1;
  localparam logic [1:0] REG_CHECK_MAGIC    = 2'd2;

  // Register reset values
  localparam logic [7:0]  HEADER_BYTES_RST   = 8'd54;
  localparam logic [15:0] EXPECTED_MAGIC_RST = 16'd0;
  localparam logic        CHECK_MAGIC_RST    = 1'b1;

  // Gather widths in bits
  localparam logic [5:0] MAGIC_BITS = 6'd16;
  localparam logic [5:0] LEN_BITS   = 6'd32;
  localparam logic [5:0] CHAR_BITS  = 6'd8;

  // Configuration seen by the parser
  typedef struct packed {
    logic [7:0]  header_bytes;
    logic [15:0] expected_magic;
    logic        check_magic;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        eom;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/lse_cfg_regs.sv @@
// APB-style configuration registers of the LSB steganography extractor.
// Depends on lse_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module lse_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lse_pkg::cfg_t     cfg
);

  logic [7:0]  header_bytes_r;
  logic [15:0] expected_magic_r;
  logic        check_magic_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r   <= lse_pkg::HEADER_BYTES_RST;
      expected_magic_r <= lse_pkg::EXPECTED_MAGIC_RST;
      check_magic_r    <= lse_pkg::CHECK_MAGIC_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        lse_pkg::REG_HEADER_BYTES:   header_bytes_r   <= pwdata[7:0];
        lse_pkg::REG_EXPECTED_MAGIC: expected_magic_r <= pwdata[15:0];
        lse_pkg::REG_CHECK_MAGIC:    check_magic_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      lse_pkg::REG_HEADER_BYTES:   prdata = {24'd0, header_bytes_r};
      lse_pkg::REG_EXPECTED_MAGIC: prdata = {16'd0, expected_magic_r};
      lse_pkg::REG_CHECK_MAGIC:    prdata = {31'd0, check_magic_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.header_bytes   = header_bytes_r;
  assign cfg.expected_magic = expected_magic_r;
  assign cfg.check_magic    = check_magic_r;

endmodule

`default_nettype wire

@@ rtl/lse_parser.sv @@
// Parse state of the LSB steganography extractor: header skip, bit gathering
// and the message phases, one image byte per step. Depends on lse_pkg.
`default_nettype none

module lse_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic          image_bit,
  input  wire logic          start,
  input  wire lse_pkg::cfg_t cfg,
  output lse_pkg::res_t      res
);

  lse_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      header_count_r, header_count_nxt;
  logic [4:0]      bit_count_r, bit_count_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [31:0]     remaining_r, remaining_nxt;

  lse_pkg::phase_t ph, ph_g;
  logic [7:0]      hc;
  logic [4:0]      bc;
  logic [31:0]     acc, acc_set, rem, rem_dec;
  logic [5:0]      width, bc_inc;
  logic            done;

  always_comb begin
    // Restart flag clears the parse before this byte is used
    ph  = start ? lse_pkg::PH_HEADER : phase_r;
    hc  = start ? 8'd0 : header_count_r;
    bc  = start ? 5'd0 : bit_count_r;
    acc = start ? 32'd0 : acc_r;
    rem = start ? 32'd0 : remaining_r;

    // Header done: this byte already carries a magic bit
    ph_g = ph;
    if (ph == lse_pkg::PH_HEADER && hc >= cfg.header_bytes) begin
      ph_g = lse_pkg::PH_MAGIC;
    end

    unique case (ph_g) inside
      lse_pkg::PH_MAGIC:                         width = lse_pkg::MAGIC_BITS;
      lse_pkg::PH_EXT_LEN, lse_pkg::PH_DAT_LEN:  width = lse_pkg::LEN_BITS;
      default:                                   width = lse_pkg::CHAR_BITS;
    endcase

    acc_set = acc | (32'(image_bit) << bc);
    bc_inc  = {1'b0, bc} + 6'd1;
    done    = bc_inc >= width;
    rem_dec = rem - 32'd1;

    phase_nxt        = ph_g;
    header_count_nxt = hc;
    bit_count_nxt    = done ? 5'd0 : bc_inc[4:0];
    acc_nxt          = done ? 32'd0 : acc_set;
    remaining_nxt    = rem;
    res.valid        = 1'b0;
    res.kind         = lse_pkg::KIND_EXT_LEN;
    res.value        = acc_set;
    res.eom          = 1'b0;

    unique case (ph_g)
      lse_pkg::PH_HEADER: begin
        // Still skipping: count and drop the byte
        header_count_nxt = hc + 8'd1;
        bit_count_nxt    = bc;
        acc_nxt          = acc;
      end
      lse_pkg::PH_MAGIC: begin
        if (done) begin
          if (cfg.check_magic && acc_set[15:0] != cfg.expected_magic) begin
            phase_nxt = lse_pkg::PH_DONE;
            res.valid = 1'b1;
            res.kind  = lse_pkg::KIND_MISMATCH;
            res.value = {16'd0, acc_set[15:0]};
            res.eom   = 1'b1;
          end else begin
            phase_nxt = lse_pkg::PH_EXT_LEN;
          end
        end
      end
      lse_pkg::PH_EXT_LEN: begin
        if (done) begin
          remaining_nxt = acc_set;
          phase_nxt     = (acc_set == 32'd0) ? lse_pkg::PH_DAT_LEN : lse_pkg::PH_EXT_CHR;
          res.valid     = 1'b1;
          res.kind      = lse_pkg::KIND_EXT_LEN;
        end
      end
      lse_pkg::PH_EXT_CHR: begin
        if (done) begin
          remaining_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = lse_pkg::PH_DAT_LEN;
          end
          res.valid = 1'b1;
          res.kind  = lse_pkg::KIND_EXT_CHR;
          res.value = {24'd0, acc_set[7:0]};
        end
      end
      lse_pkg::PH_DAT_LEN: begin
        if (done) begin
          remaining_nxt = acc_set;
          phase_nxt     = (acc_set == 32'd0) ? lse_pkg::PH_DONE : lse_pkg::PH_DAT_BYTE;
          res.valid     = 1'b1;
          res.kind      = lse_pkg::KIND_DAT_LEN;
          res.eom       = (acc_set == 32'd0);
        end
      end
      lse_pkg::PH_DAT_BYTE: begin
        if (done) begin
          remaining_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = lse_pkg::PH_DONE;
          end
          res.valid = 1'b1;
          res.kind  = lse_pkg::KIND_DAT_BYTE;
          res.value = {24'd0, acc_set[7:0]};
          res.eom   = (rem_dec == 32'd0);
        end
      end
      default: begin
        // Message finished or aborted: ignore bytes until a start flag
        bit_count_nxt = bc;
        acc_nxt       = acc;
      end
    endcase
  end

  // Advance the parse on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= lse_pkg::PH_HEADER;
      header_count_r <= 8'd0;
      bit_count_r    <= 5'd0;
      acc_r          <= 32'd0;
      remaining_r    <= 32'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      acc_r          <= acc_nxt;
      remaining_r    <= remaining_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lsb_stego_extractor_top.sv @@
// Top level of the LSB steganography extractor: config port, parser and
// a two-entry output stage. Depends on lse_pkg, lse_cfg_regs and lse_parser.
//
// Usage:
//   Image bytes enter on the in_ channel (valid/ready), one byte per beat;
//   in_start_of_image marks the first byte of a new image and restarts the
//   parse. After header_bytes skipped bytes, bit 0 of each byte is gathered
//   LSB first: a 16-bit magic word, a 32-bit extension length, the extension
//   characters, a 32-bit data length and the data bytes.
//   Each completed length, character or byte, or a magic mismatch, leaves on
//   the out_ channel as one beat through the output register or skid entry.
//   Throughput is one byte per cycle while in_ready is high; the parse
//   state update is a single combinational step, state regs to output reg.
//   The output stage holds two results, so a stalled receiver does not stop
//   input at once; in_ready drops only while both entries are full.
//   Registers (APB, byte addresses 0, 4, 8) are to be written only while
//   the stream is idle; the block does not enforce this. Reset restores
//   the register defaults (54 header bytes, magic 0, magic check on),
//   empties the output stage and puts the parse in the header skip phase.
`default_nettype none

module lsb_stego_extractor_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_image_byte,
  input  wire logic         in_start_of_image,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_item_kind,
  output logic [31:0]       out_item_value,
  output logic              out_end_of_message,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  lse_pkg::cfg_t cfg;
  lse_pkg::res_t res;
  logic          in_fire, out_fire, push;
  logic          out_valid_r, skid_valid_r;
  logic [2:0]    out_kind_r, skid_kind_r;
  logic [31:0]   out_value_r, skid_value_r;
  logic          out_eom_r, skid_eom_r;

  lse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lse_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .image_bit (in_image_byte[0]),
    .start     (in_start_of_image),
    .cfg       (cfg),
    .res       (res)
  );

  assign in_ready = ~skid_valid_r;
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid_r & out_ready;
  assign push     = in_fire & res.valid;

  // Output stage control: main entry first, skid entry while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (out_fire && skid_valid_r) begin
      out_kind_r  <= skid_kind_r;
      out_value_r <= skid_value_r;
      out_eom_r   <= skid_eom_r;
    end else if (push && (out_fire || !out_valid_r)) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
      out_eom_r   <= res.eom;
    end
    if (push && out_valid_r && (!out_fire || skid_valid_r)) begin
      skid_kind_r  <= res.kind;
      skid_value_r <= res.value;
      skid_eom_r   <= res.eom;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item_kind      = out_kind_r;
  assign out_item_value     = out_value_r;
  assign out_end_of_message = out_eom_r;

endmodule

`default_nettype wire

@@ rtl/lse_checker.sv @@
// Port-level checks on the result channel of the LSB steganography extractor,
// bound to the top level. Depends on lse_pkg and the assertion macro header.
`default_nettype none
`include "lsb_stego_extractor_top_assert.svh"

module lse_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  wire logic [2:0]   out_item_kind,
  input  wire logic [31:0]  out_item_value,
  input  wire logic         out_end_of_message
);

  logic [35:0] out_beat;
  logic        kind_ext, kind_byte, kind_mismatch, kind_legal;

  // Collect the payload and classify the kind
  assign out_beat      = {out_item_kind, out_item_value, out_end_of_message};
  assign kind_ext      = (out_item_kind == lse_pkg::KIND_EXT_LEN) ||
                         (out_item_kind == lse_pkg::KIND_EXT_CHR);
  assign kind_byte     = (out_item_kind == lse_pkg::KIND_EXT_CHR) ||
                         (out_item_kind == lse_pkg::KIND_DAT_BYTE);
  assign kind_mismatch = (out_item_kind == lse_pkg::KIND_MISMATCH);
  assign kind_legal    = kind_ext || kind_byte || kind_mismatch ||
                         (out_item_kind == lse_pkg::KIND_DAT_LEN);

  // Stalled beat holds
  `LSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // Only defined kinds leave the block
  `LSE_ASSERT_NOW(a_kind_legal, out_valid, kind_legal)

  // A mismatch always ends the message
  `LSE_ASSERT_NOW(a_mismatch_eom, out_valid && kind_mismatch, out_end_of_message)

  // Extension items never end the message
  `LSE_ASSERT_NOW(a_ext_no_eom, out_valid && kind_ext, !out_end_of_message)

  // Characters and data bytes fit in a byte
  `LSE_ASSERT_NOW(a_char_width, out_valid && kind_byte, out_item_value[31:8] == 24'd0)

endmodule

bind lsb_stego_extractor_top lse_checker u_lse_checker (.*);

`default_nettype wire
